// ===== sv/psqm_pkg.sv =====
// Shared types and codes of the process state queue manager.
`timescale 1ns / 1ps
`default_nettype none
package psqm_pkg;

    localparam logic [2:0] MODE_CREATE    = 3'd0;
    localparam logic [2:0] MODE_SUSPEND   = 3'd1;
    localparam logic [2:0] MODE_RESUME    = 3'd2;
    localparam logic [2:0] MODE_EXIT      = 3'd3;
    localparam logic [2:0] MODE_TERMINATE = 3'd4;
    localparam logic [2:0] MODE_SELECT    = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] LST_READY = 2'd0;
    localparam logic [1:0] LST_SUSP  = 2'd1;
    localparam logic [1:0] LST_DEF   = 2'd2;

    localparam logic [31:0] FLAG_READY     = 32'h8000_0000;
    localparam logic [31:0] FLAG_SUSPENDED = 32'h4000_0000;
    localparam logic [31:0] FLAG_DEFUNCT   = 32'h2000_0000;
    localparam logic [31:0] FLAG_SUDO      = 32'h1000_0000;
    localparam logic [31:0] STATE_MASK     = 32'hE000_0000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] pid;
        logic        sudo;
        logic [27:0] term_code;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_pid;
        logic [31:0] flags_word;
        logic [4:0]  ready_count;
        logic [4:0]  suspended_count;
        logic [4:0]  defunct_count;
    } t_rsp;

endpackage
`default_nettype wire

// ===== sv/psqm_lists.sv =====
// Storage of the ready, suspended and defunct slot order lists.
`timescale 1ns / 1ps
`default_nettype none
module psqm_lists
    import psqm_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire                           i_clk,
    input  wire                           i_we,
    input  wire [1:0]                     i_wlist,
    input  wire [$clog2(TABLE_DEPTH)-1:0] i_wpos,
    input  wire [$clog2(TABLE_DEPTH)-1:0] i_wdata,
    input  wire [1:0]                     i_rlist,
    input  wire [$clog2(TABLE_DEPTH)-1:0] i_rpos,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rdata
);
    localparam int IW = $clog2(TABLE_DEPTH);

    logic [IW-1:0] r_ready [TABLE_DEPTH];
    logic [IW-1:0] r_susp  [TABLE_DEPTH];
    logic [IW-1:0] r_def   [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            case (i_wlist)
                LST_READY: r_ready[i_wpos] <= i_wdata;
                LST_SUSP:  r_susp[i_wpos]  <= i_wdata;
                default:   r_def[i_wpos]   <= i_wdata;
            endcase
        end
    end

    always_comb begin
        case (i_rlist)
            LST_READY: o_rdata = r_ready[i_rpos];
            LST_SUSP:  o_rdata = r_susp[i_rpos];
            default:   o_rdata = r_def[i_rpos];
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/process_state_queue_manager_unit.sv =====
// Top level of the process state queue manager.
// A small sequencer runs each command around one shared pid comparator that
// walks the lists one entry per cycle. Create scans the slots for a free one;
// suspend, resume and terminate search a list, select takes the head of the
// ready list, and each shifts that list's tail down one entry a cycle; suspend,
// terminate and exit then walk the target list and shift it up to make room.
// The list walks set how long busy stays high. The result shows on o_rsp with
// o_strobe for one cycle, in the same cycle that busy drops, and the receiver
// cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module process_state_queue_manager_unit
    import psqm_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int PID_BITS    = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_strobe,
    output t_rsp      o_rsp
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FREE, S_FIND, S_REM, S_POST, S_APP, S_INS_FIND, S_INS_SHIFT, S_DONE
    } t_state;

    t_state               r_state;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [PID_BITS-1:0]  r_pid   [TABLE_DEPTH];
    logic [31:0]          r_flags [TABLE_DEPTH];
    logic [CW-1:0]        r_cnt   [3];
    logic [IW-1:0]        r_run;
    logic                 r_run_v;

    logic [2:0]           r_mode;
    logic [PID_BITS-1:0]  r_key;
    logic                 r_sudo;
    logic [27:0]          r_code;
    logic [1:0]           r_err;
    logic                 r_has_slot;
    logic [1:0]           r_which;
    logic [CW-1:0]        r_pos;
    logic [CW-1:0]        r_ins;
    logic [IW-1:0]        r_slot;

    logic                 w_we;
    logic [1:0]           w_wlist;
    logic [CW-1:0]        w_wpos;
    logic [IW-1:0]        w_wdata;
    logic [CW-1:0]        w_rpos;
    logic [IW-1:0]        w_rd;
    logic [CW-1:0]        w_pos_inc;
    logic [CW-1:0]        w_cnt;
    logic [PID_BITS-1:0]  w_cur_pid;
    logic                 w_eq;
    logic                 w_gt;

    assign w_pos_inc = r_pos + 1'b1;
    assign w_cnt     = r_cnt[r_which];
    assign busy      = (r_state != S_IDLE);

    // shared comparator: list entry pid against the search key
    assign w_cur_pid = r_pid[w_rd];
    assign w_eq      = (w_cur_pid == r_key);
    assign w_gt      = (w_cur_pid > r_key);

    always_comb begin
        w_we    = 1'b0;
        w_wlist = r_which;
        w_wpos  = r_pos;
        w_wdata = w_rd;
        w_rpos  = r_pos;
        case (r_state)
            S_REM: begin
                w_rpos = w_pos_inc;
                w_we   = (w_pos_inc < w_cnt);
            end
            S_APP: begin
                w_we    = 1'b1;
                w_wlist = LST_READY;
                w_wpos  = r_cnt[LST_READY];
                w_wdata = r_slot;
            end
            S_INS_SHIFT: begin
                w_rpos = r_pos - 1'b1;
                w_we   = 1'b1;
                if (r_pos == r_ins) begin
                    w_wdata = r_slot;
                end
            end
            default: ;
        endcase
    end

    psqm_lists #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_lists (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_wlist (w_wlist),
        .i_wpos  (w_wpos[IW-1:0]),
        .i_wdata (w_wdata),
        .i_rlist (r_which),
        .i_rpos  (w_rpos[IW-1:0]),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_cnt    <= '{default: '0};
            r_run_v  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode     <= i_cmd.mode;
                        r_key      <= PID_BITS'(i_cmd.pid);
                        r_sudo     <= i_cmd.sudo;
                        r_code     <= i_cmd.term_code;
                        r_err      <= ST_OK;
                        r_has_slot <= 1'b0;
                        r_pos      <= '0;
                        case (i_cmd.mode) inside
                            MODE_CREATE: r_state <= S_FREE;
                            MODE_SUSPEND, MODE_TERMINATE: begin
                                r_which <= LST_READY;
                                r_state <= S_FIND;
                            end
                            MODE_RESUME: begin
                                r_which <= LST_SUSP;
                                r_state <= S_FIND;
                            end
                            MODE_EXIT: begin
                                if (!r_run_v) begin
                                    r_err   <= ST_NOTFOUND;
                                    r_state <= S_DONE;
                                end else begin
                                    r_slot     <= r_run;
                                    r_has_slot <= 1'b1;
                                    r_run_v    <= 1'b0;
                                    r_flags[r_run] <= (r_flags[r_run] & FLAG_SUDO)
                                        | FLAG_DEFUNCT | {4'd0, i_cmd.term_code};
                                    r_key      <= r_pid[r_run];
                                    r_which    <= LST_DEF;
                                    r_state    <= S_INS_FIND;
                                end
                            end
                            MODE_SELECT: begin
                                if (r_cnt[LST_READY] == '0) begin
                                    r_err   <= ST_EMPTY;
                                    r_state <= S_DONE;
                                end else begin
                                    r_which <= LST_READY;
                                    r_state <= S_FIND;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_FREE: begin
                    if (!r_valid[r_pos[IW-1:0]]) begin
                        r_valid[r_pos[IW-1:0]] <= 1'b1;
                        r_pid[r_pos[IW-1:0]]   <= r_key;
                        r_flags[r_pos[IW-1:0]] <= FLAG_READY | (r_sudo ? FLAG_SUDO : 32'd0);
                        r_slot     <= r_pos[IW-1:0];
                        r_has_slot <= 1'b1;
                        r_state    <= S_APP;
                    end else if (r_pos == CW'(TABLE_DEPTH - 1)) begin
                        r_err   <= ST_FULL;
                        r_state <= S_DONE;
                    end else begin
                        r_pos <= w_pos_inc;
                    end
                end
                S_FIND: begin
                    if (r_pos >= w_cnt) begin
                        if (r_mode == MODE_TERMINATE && r_which == LST_READY) begin
                            r_which <= LST_SUSP;
                            r_pos   <= '0;
                        end else begin
                            r_err   <= ST_NOTFOUND;
                            r_state <= S_DONE;
                        end
                    end else if (w_eq || r_mode == MODE_SELECT) begin
                        r_slot     <= w_rd;
                        r_has_slot <= 1'b1;
                        r_state    <= S_REM;
                    end else begin
                        r_pos <= w_pos_inc;
                    end
                end
                S_REM: begin
                    // shift the tail down one entry per cycle
                    if (w_pos_inc < w_cnt) begin
                        r_pos <= w_pos_inc;
                    end else begin
                        r_cnt[r_which] <= w_cnt - 1'b1;
                        r_state        <= S_POST;
                    end
                end
                S_POST: begin
                    r_pos <= '0;
                    r_key <= r_pid[r_slot];
                    case (r_mode)
                        MODE_SUSPEND: begin
                            r_flags[r_slot] <= (r_flags[r_slot] & ~STATE_MASK)
                                | FLAG_SUSPENDED;
                            r_which <= LST_SUSP;
                            r_state <= S_INS_FIND;
                        end
                        MODE_RESUME: begin
                            r_flags[r_slot] <= (r_flags[r_slot] & ~STATE_MASK) | FLAG_READY;
                            r_state <= S_APP;
                        end
                        MODE_TERMINATE: begin
                            r_flags[r_slot] <= (r_flags[r_slot] & FLAG_SUDO)
                                | FLAG_DEFUNCT | {4'd0, r_code};
                            r_which <= LST_DEF;
                            r_state <= S_INS_FIND;
                        end
                        default: begin
                            // select: drop the old running record
                            if (r_run_v) begin
                                r_valid[r_run] <= 1'b0;
                            end
                            r_run   <= r_slot;
                            r_run_v <= 1'b1;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_APP: begin
                    r_cnt[LST_READY] <= r_cnt[LST_READY] + 1'b1;
                    r_state          <= S_DONE;
                end
                S_INS_FIND: begin
                    // advance past entries with pid not above the key
                    if (r_pos < w_cnt && !w_gt) begin
                        r_pos <= w_pos_inc;
                    end else begin
                        r_ins   <= r_pos;
                        r_pos   <= w_cnt;
                        r_state <= S_INS_SHIFT;
                    end
                end
                S_INS_SHIFT: begin
                    if (r_pos == r_ins) begin
                        r_cnt[r_which] <= w_cnt + 1'b1;
                        r_state        <= S_DONE;
                    end else begin
                        r_pos <= r_pos - 1'b1;
                    end
                end
                S_DONE: begin
                    o_strobe       <= 1'b1;
                    o_rsp.status   <= r_err;
                    if (r_err == ST_OK && r_has_slot) begin
                        o_rsp.out_pid    <= 16'(r_pid[r_slot]);
                        o_rsp.flags_word <= r_flags[r_slot];
                    end else begin
                        o_rsp.out_pid    <= '0;
                        o_rsp.flags_word <= '0;
                    end
                    o_rsp.ready_count     <= 5'(r_cnt[LST_READY]);
                    o_rsp.suspended_count <= 5'(r_cnt[LST_SUSP]);
                    o_rsp.defunct_count   <= 5'(r_cnt[LST_DEF]);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/psqm_checker.sv =====
// Port-level checks of the process state queue manager, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module psqm_checker
    import psqm_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       start,
    input wire       busy,
    input wire       o_strobe,
    input wire t_rsp o_rsp
);

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a preceding busy item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("item finished without a result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status != ST_OK) |->
            (o_rsp.out_pid == 16'd0 && o_rsp.flags_word == 32'd0))
        else $error("error result carries a pid or flags");

    a_one_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $onehot0(o_rsp.flags_word[31:29]))
        else $error("result flags hold more than one list state");

endmodule

bind process_state_queue_manager_unit psqm_checker u_psqm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_rsp    (o_rsp)
);
`default_nettype wire
